FILE: design/abt_pkg.sv
// ----------------------------------------------------------------------------
// abt_pkg
// Shared constants, codes and types of the Q16 alpha-beta tracker.
// ----------------------------------------------------------------------------
package abt_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ONE_Q     = 1 << FRAC_BITS;

  localparam int unsigned ALPHA_W = 17;
  localparam int unsigned BETA_W  = 18;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned AHEAD_W = 16;
  localparam int unsigned ACC_W   = 64;
  localparam int unsigned HALF_W  = 32;

  // shared multiplier: signed 33-bit half word by signed 19-bit gain or lookahead
  localparam int unsigned MUL_A_W = HALF_W + 1;
  localparam int unsigned MUL_B_W = BETA_W + 1;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int unsigned ADDR_W = 4;

  // opcodes
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // status codes
  localparam logic ST_OK       = 1'b0;
  localparam logic ST_REJECTED = 1'b1;

  // register indexes
  localparam logic [1:0] REG_ALPHA = 2'd0;
  localparam logic [1:0] REG_BETA  = 2'd1;
  localparam logic [1:0] REG_START = 2'd2;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(32768);
  localparam logic [BETA_W-1:0]  BETA_RST  = BETA_W'(6554);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRED,
    S_RESID,
    S_A_LO,
    S_A_HI,
    S_A_ADD,
    S_B_LO,
    S_B_HI,
    S_B_ADD,
    S_RESTART,
    S_P_LO,
    S_P_HI,
    S_P_ADD,
    S_FIN
  } abt_state_t;

endpackage

FILE: design/alpha_beta_tracker_q16.sv
// A measurement word steps through prediction, residual, alpha, beta and lookahead products;
//   a restart goes straight to the lookahead product. One word is worked on at a time, set by
//   the single shared 33x19 multiplier, used for six half products per measurement, two per restart.
// The input side is held off while a word is worked on; a stalled result side holds it longer.
// Reset (synchronous, rst_n low): position and velocity clear to zero, gains go to
//   alpha 0.5 and beta 0.1, start position to zero, the result register empties.
// ----------------------------------------------------------------------------
// alpha_beta_tracker_q16
// Fixed-point Q16 alpha-beta tracker with an APB register port and stream
// channels. A small sequencer drives one shared multiplier and a 64-bit
// accumulator through the alpha, beta and lookahead products.
// ----------------------------------------------------------------------------
module alpha_beta_tracker_q16
  import abt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [47:0]        in_tdata,   // [31:0] measured_position, [47:32] lookahead
  input  logic               in_tuser,   // [0] opcode

  // result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [95:0]        out_tdata,  // [31:0] filtered_position, [63:32] rate_estimate,
                                         // [95:64] projected_position
  output logic               out_tuser,  // [0] status

  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [ALPHA_W-1:0]       alpha_r;
  logic [BETA_W-1:0]        beta_r;
  logic [POS_W-1:0]         start_r;

  abt_state_t               state_r, state_nxt;

  logic                     op_r;
  logic signed [POS_W-1:0]  meas_r;
  logic signed [AHEAD_W-1:0] ahead_r;

  logic signed [ACC_W-1:0]  pos_r;
  logic signed [ACC_W-1:0]  vel_r;
  logic signed [ACC_W-1:0]  acc_r;     // prediction, later the projection
  logic signed [ACC_W-1:0]  resid_r;
  logic signed [ACC_W-1:0]  prod_r;    // low half product, sign extended
  logic [HALF_W-1:0]        hi_r;      // high half product, low 32 bits
  logic                     status_r;

  logic                     out_tvalid_r;
  logic [95:0]              out_tdata_r;
  logic                     out_tuser_r;

  // --------------------------------------------------------------------------
  // Shared multiplier and helpers
  // --------------------------------------------------------------------------
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [ACC_W-1:0]   prod_full;
  logic signed [ACC_W-1:0]   corr;
  logic [ACC_W-1:0]          mul_src;
  logic [1:0]                mul_sel;    // 0 alpha, 1 beta, 2 lookahead
  logic                      mul_hi;
  logic                      in_acc;
  logic                      out_load;
  logic                      cfg_wr;
  logic [BETA_W+2:0]         beta_limit;
  logic                      gains_ok;
  logic [31:0]               rate_sat;

  localparam logic [1:0] MSEL_ALPHA = 2'd0;
  localparam logic [1:0] MSEL_BETA  = 2'd1;
  localparam logic [1:0] MSEL_AHEAD = 2'd2;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign in_acc = in_tvalid & in_tready;
  assign out_load = (state_r == S_FIN) && (!out_tvalid_r || out_tready);

  // pick the half word of residual or velocity, then the gain or lookahead
  always_comb begin
    mul_src = (mul_sel == MSEL_AHEAD) ? vel_r : resid_r;
    if (mul_hi) begin
      mul_a = {mul_src[ACC_W-1], mul_src[ACC_W-1:HALF_W]};
    end else begin
      mul_a = {1'b0, mul_src[HALF_W-1:0]};
    end
    case (mul_sel)
      MSEL_ALPHA: mul_b = MUL_B_W'({2'b00, alpha_r});
      MSEL_BETA:  mul_b = MUL_B_W'({1'b0, beta_r});
      MSEL_AHEAD: mul_b = MUL_B_W'(signed'(ahead_r));
      default:    mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // low product plus high product moved up by one half word, modulo 2^64
  assign prod_full = {prod_r[ACC_W-1:HALF_W] + hi_r, prod_r[HALF_W-1:0]};
  assign corr      = prod_full >>> FRAC_BITS;

  // stable region: 0 < alpha <= 1.0, 0 < beta <= 4.0 - 2*alpha
  assign beta_limit = (BETA_W+3)'(4 * ONE_Q) - (BETA_W+3)'({alpha_r, 1'b0});
  assign gains_ok   = (alpha_r != '0) && (alpha_r <= ALPHA_W'(ONE_Q)) &&
                      (beta_r != '0) && ((BETA_W+3)'(beta_r) <= beta_limit);

  // saturate velocity to int32: in range when the top 33 bits agree
  always_comb begin
    if (vel_r[ACC_W-1:HALF_W-1] == '0 || vel_r[ACC_W-1:HALF_W-1] == '1) begin
      rate_sat = vel_r[HALF_W-1:0];
    end else if (vel_r[ACC_W-1]) begin
      rate_sat = 32'h8000_0000;
    end else begin
      rate_sat = 32'h7FFF_FFFF;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:    if (in_acc) state_nxt = (in_tuser == OP_RESTART) ? S_RESTART : S_PRED;
      S_PRED:    state_nxt = S_RESID;
      S_RESID:   state_nxt = S_A_LO;
      S_A_LO:    state_nxt = S_A_HI;
      S_A_HI:    state_nxt = S_A_ADD;
      S_A_ADD:   state_nxt = S_B_LO;
      S_B_LO:    state_nxt = S_B_HI;
      S_B_HI:    state_nxt = S_B_ADD;
      S_B_ADD:   state_nxt = S_P_LO;
      S_RESTART: state_nxt = S_P_LO;
      S_P_LO:    state_nxt = S_P_HI;
      S_P_HI:    state_nxt = S_P_ADD;
      S_P_ADD:   state_nxt = S_FIN;
      S_FIN:     if (out_load) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: control outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_tready = 1'b0;
    mul_sel   = MSEL_ALPHA;
    mul_hi    = 1'b0;
    case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_A_LO: mul_sel = MSEL_ALPHA;
      S_A_HI: begin
        mul_sel = MSEL_ALPHA;
        mul_hi  = 1'b1;
      end
      S_B_LO: mul_sel = MSEL_BETA;
      S_B_HI: begin
        mul_sel = MSEL_BETA;
        mul_hi  = 1'b1;
      end
      S_P_LO: mul_sel = MSEL_AHEAD;
      S_P_HI: begin
        mul_sel = MSEL_AHEAD;
        mul_hi  = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      alpha_r      <= ALPHA_RST;
      beta_r       <= BETA_RST;
      start_r      <= '0;
      pos_r        <= '0;
      vel_r        <= '0;
    end else begin
      state_r <= state_nxt;

      // load a new result word, or drop the one just taken
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      if (cfg_wr) begin
        case (paddr[3:2])
          REG_ALPHA: alpha_r <= pwdata[ALPHA_W-1:0];
          REG_BETA:  beta_r  <= pwdata[BETA_W-1:0];
          REG_START: start_r <= pwdata[POS_W-1:0];
          default:   start_r <= start_r;
        endcase
      end

      // fold the scaled residual into position, then velocity; a restart with valid gains loads the start position
      case (state_r)
        S_A_ADD: pos_r <= acc_r + corr;
        S_B_ADD: vel_r <= vel_r + corr;
        S_RESTART: begin
          if (gains_ok) begin
            pos_r <= ACC_W'(signed'(start_r)) <<< FRAC_BITS;
            vel_r <= '0;
          end
        end
        default: pos_r <= pos_r;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_tuser;
      meas_r  <= in_tdata[POS_W-1:0];
      ahead_r <= in_tdata[POS_W+AHEAD_W-1:POS_W];
    end
    case (state_r)
      S_PRED: begin
        acc_r    <= pos_r + vel_r;
        status_r <= ST_OK;
      end
      S_RESID:   resid_r <= (ACC_W'(meas_r) <<< FRAC_BITS) - acc_r;
      S_A_LO, S_B_LO, S_P_LO: prod_r <= ACC_W'(mul_p);
      S_A_HI, S_B_HI, S_P_HI: hi_r <= mul_p[HALF_W-1:0];
      S_RESTART: status_r <= gains_ok ? ST_OK : ST_REJECTED;
      S_P_ADD:   acc_r <= pos_r + prod_full;
      default:   hi_r <= hi_r;
    endcase
    if (out_load) begin
      out_tdata_r <= {acc_r[FRAC_BITS+31:FRAC_BITS], rate_sat,
                      pos_r[FRAC_BITS+31:FRAC_BITS]};
      out_tuser_r <= (op_r == OP_RESTART) ? status_r : ST_OK;
    end
  end

  // register read
  always_comb begin
    case (paddr[3:2])
      REG_ALPHA: prdata = 32'(alpha_r);
      REG_BETA:  prdata = 32'(beta_r);
      REG_START: prdata = start_r;
      default:   prdata = '0;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

FILE: dv/alpha_beta_tracker_q16_test.sv
// ----------------------------------------------------------------------------
// alpha_beta_tracker_q16_test
// Self-checking bench for the Q16 alpha-beta tracker. A queue-fed driver pushes
// measurement and restart words into the input stream. A clocked predictor
// follows every accepted word and computes the expected estimate. A monitor
// checks each result word field by field. The gain and start registers are
// rewritten over the APB port between phases, always with the block drained.
// ----------------------------------------------------------------------------
module alpha_beta_tracker_q16_test;
  import abt_pkg::*;

  localparam longint RATE_MAX = 64'sd2147483647;
  localparam longint RATE_MIN = -64'sd2147483648;

  // One input word and one result word, as the bench sees them.
  typedef struct {
    logic               op;
    logic signed [31:0] meas;
    logic signed [15:0] ahead;
  } track_word_t;

  typedef struct {
    logic [31:0] pos;
    logic [31:0] rate;
    logic [31:0] proj;
    logic        status;
  } track_est_t;

  logic        clk;
  logic        rst_n      = 1'b0;

  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // [31:0] measured_position, [47:32] lookahead
  logic        in_tuser   = 1'b0; // [0] opcode

  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;         // [31:0] filtered_position, [63:32] rate_estimate,
                                  // [95:64] projected_position
  logic        out_tuser;         // [0] status

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  alpha_beta_tracker_q16 u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Shadow copy of the registers and of the tracker state.
  logic [ALPHA_W-1:0] alpha_q = ALPHA_RST;
  logic [BETA_W-1:0]  beta_q  = BETA_RST;
  logic [31:0]        start_q = '0;
  logic [63:0]        pos_q   = '0;
  logic [63:0]        vel_q   = '0;

  track_word_t pending_words[$];
  track_est_t  expected_estimates[$];
  track_word_t word_in_flight;

  int  queued_total  = 0;
  int  results_seen  = 0;
  int  fail_count    = 0;
  int  gap_left      = 0;
  int  stall_left    = 0;
  bit  quiet         = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Advance the shadow tracker by one word and return the estimate it reads out.
  function automatic track_est_t advance_track(input track_word_t w);
    logic [63:0]        pred;
    logic [63:0]        resid;
    logic [63:0]        prod;
    logic [63:0]        sum;
    logic signed [63:0] shifted;
    longint             lim;
    longint             vel_s;
    bit                 gains_ok;
    track_est_t         e;
    e.status = ST_OK;
    if (w.op == OP_MEASURE) begin
      // predict, form the residual, then correct position and velocity
      pred    = pos_q + vel_q;
      resid   = ({{32{w.meas[31]}}, w.meas} << FRAC_BITS) - pred;
      prod    = 64'(alpha_q) * resid;
      shifted = $signed(prod) >>> FRAC_BITS;
      pos_q   = pred + shifted;
      prod    = 64'(beta_q) * resid;
      shifted = $signed(prod) >>> FRAC_BITS;
      vel_q   = vel_q + shifted;
    end else begin
      // restart only inside the stable region: 0 < a <= 1, 0 < b <= 4 - 2a
      lim      = 4 * longint'(ONE_Q) - 2 * longint'(alpha_q);
      gains_ok = alpha_q != 0 && longint'(alpha_q) <= longint'(ONE_Q) &&
                 beta_q != 0 && longint'(beta_q) <= lim;
      if (gains_ok) begin
        pos_q = {{32{start_q[31]}}, start_q} << FRAC_BITS;
        vel_q = '0;
      end else begin
        e.status = ST_REJECTED;
      end
    end
    // saturate the velocity readout, truncate the two positions
    vel_s = vel_q;
    if (vel_s > RATE_MAX)
      e.rate = 32'h7FFF_FFFF;
    else if (vel_s < RATE_MIN)
      e.rate = 32'h8000_0000;
    else
      e.rate = vel_q[31:0];
    shifted = $signed(pos_q) >>> FRAC_BITS;
    e.pos   = shifted[31:0];
    sum     = pos_q + vel_q * {{48{w.ahead[15]}}, w.ahead};
    shifted = $signed(sum) >>> FRAC_BITS;
    e.proj  = shifted[31:0];
    return e;
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch on %s at %0t: expected %h, got %h", what, $realtime, want, got);
  endfunction

  // Driver: hold a word until it is taken, then advance to the next pending
  // one, with random gaps unless the run has gone quiet.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left  <= 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_estimates.push_back(advance_track(word_in_flight));
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left  <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          gap_left  <= $urandom_range(0, 2);
          in_tvalid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          word_in_flight = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {word_in_flight.ahead, word_in_flight.meas};
          in_tuser  <= word_in_flight.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every result word against the oldest expectation and
  // stall the result side in short random bursts unless the run has gone quiet.
  always @(posedge clk) begin
    track_est_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_estimates.size() == 0) begin
          note_mismatch("unexpected word", '0, out_tdata[31:0]);
        end else begin
          want = expected_estimates.pop_front();
          if (out_tdata[31:0] !== want.pos)
            note_mismatch("filtered_position", want.pos, out_tdata[31:0]);
          if (out_tdata[63:32] !== want.rate)
            note_mismatch("rate_estimate", want.rate, out_tdata[63:32]);
          if (out_tdata[95:64] !== want.proj)
            note_mismatch("projected_position", want.proj, out_tdata[95:64]);
          if (out_tuser !== want.status)
            note_mismatch("status", 32'(want.status), 32'(out_tuser));
        end
      end
      if (quiet) begin
        out_tready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic queue_word(input logic op, input logic [31:0] meas,
                            input logic [15:0] ahead);
    track_word_t w;
    w.op    = op;
    w.meas  = meas;
    w.ahead = ahead;
    pending_words.push_back(w);
    queued_total++;
  endtask

  // Hold the stimulus until every queued word has produced its result.
  task automatic wait_drained();
    while (results_seen < queued_total || pending_words.size() != 0)
      @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ALPHA: alpha_q = value[ALPHA_W-1:0];
      REG_BETA:  beta_q  = value[BETA_W-1:0];
      REG_START: start_q = value;
      default: ;
    endcase
  endtask

  // Drain the block, then rewrite all three registers.
  task automatic set_gains(input int unsigned alpha, input int unsigned beta,
                           input logic [31:0] start);
    wait_drained();
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_BETA, beta);
    write_reg(REG_START, start);
  endtask

  // Random words: mostly a noisy straight-line track, some wild jumps, a few
  // restarts. Lookahead stays short most of the time.
  task automatic fill_phase(input int count);
    logic [31:0]  base;
    logic [31:0]  slope;
    logic [31:0]  meas;
    logic [15:0]  ahead;
    int unsigned  pick;
    base  = $urandom;
    slope = $urandom_range(0, 1) ? $urandom_range(0, 2000) - 1000 : $urandom;
    for (int k = 0; k < count; k++) begin
      pick  = $urandom_range(0, 99);
      ahead = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                                            16'($urandom_range(0, 64) - 32);
      if (pick < 8) begin
        queue_word(OP_RESTART, $urandom, ahead);
      end else if (pick < 20) begin
        queue_word(OP_MEASURE, $urandom, ahead);
      end else begin
        meas = base + slope * k + ($urandom_range(0, 200) - 100);
        queue_word(OP_MEASURE, meas, ahead);
      end
    end
  endtask

  initial begin
    int unsigned a;
    int unsigned b;
    logic [31:0] start;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: default gains, field extremes, a restart that passes.
    queue_word(OP_MEASURE, 32'd0, 16'd0);
    queue_word(OP_MEASURE, 32'd100, 16'd1);
    queue_word(OP_MEASURE, 32'h7FFF_FFFF, 16'h7FFF);
    queue_word(OP_MEASURE, 32'h8000_0000, 16'h8000);
    queue_word(OP_MEASURE, 32'hFFFF_FFFF, 16'hFFFF);
    queue_word(OP_RESTART, 32'hA5A5_5A5A, 16'd5);
    queue_word(OP_MEASURE, 32'd1000, 16'd0);

    // Start position extremes.
    set_gains(32'(ALPHA_RST), 32'(BETA_RST), 32'h7FFF_FFFF);
    queue_word(OP_RESTART, 32'd0, 16'h7FFF);
    queue_word(OP_MEASURE, 32'h7FFF_FFFF, 16'h7FFF);
    set_gains(32'(ALPHA_RST), 32'(BETA_RST), 32'h8000_0000);
    queue_word(OP_RESTART, 32'hFFFF_FFFF, 16'h8000);
    queue_word(OP_MEASURE, 32'h8000_0000, 16'h8000);

    // Stable region edges: zero alpha, alpha above one, beta on and past
    // the limit, zero beta, smallest alpha with largest allowed beta.
    set_gains(0, 32'(BETA_RST), 32'd77);
    queue_word(OP_RESTART, 32'd0, 16'd1);
    set_gains(ONE_Q + 1, 1, 32'd77);
    queue_word(OP_RESTART, 32'd0, 16'd1);
    set_gains(ONE_Q, 2 * ONE_Q, 32'd77);
    queue_word(OP_RESTART, 32'd0, 16'd1);
    queue_word(OP_MEASURE, 32'd500, 16'd3);
    set_gains(ONE_Q, 2 * ONE_Q + 1, 32'd77);
    queue_word(OP_RESTART, 32'd0, 16'd1);
    set_gains(1, 0, 32'd9);
    queue_word(OP_RESTART, 32'd0, 16'd1);
    set_gains(1, 4 * ONE_Q - 2, 32'd9);
    queue_word(OP_RESTART, 32'd0, 16'd1);
    set_gains(1, 4 * ONE_Q - 1, 32'd9);
    queue_word(OP_RESTART, 32'd0, 16'd1);

    // Gains far outside the region still drive measurements.
    set_gains((1 << ALPHA_W) - 1, (1 << BETA_W) - 1, 32'd0);
    queue_word(OP_MEASURE, 32'h4000_0000, 16'h7FFF);
    queue_word(OP_MEASURE, 32'hC000_0000, 16'h8000);
    queue_word(OP_MEASURE, 32'd12345, 16'hFFFF);

    // Random phases, each with its own register setting. The last one runs
    // without idling on either side.
    for (int ph = 0; ph < 14; ph++) begin
      case ($urandom_range(0, 5))
        0, 1, 2, 3: begin
          a = $urandom_range(1, ONE_Q);
          b = $urandom_range(1, 4 * ONE_Q - 2 * a);
        end
        4: begin
          a = $urandom_range(0, (1 << ALPHA_W) - 1);
          b = $urandom_range(0, (1 << BETA_W) - 1);
        end
        default: begin
          a = ONE_Q;
          b = 2 * ONE_Q;
        end
      endcase
      case ($urandom_range(0, 3))
        0:       start = 32'h7FFF_FFFF;
        1:       start = 32'h8000_0000;
        default: start = $urandom;
      endcase
      set_gains(a, b, start);
      if (ph == 13) begin
        wait_drained();
        quiet = 1'b1;
      end
      fill_phase(140);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_estimates.size() == 0) begin
      $display("alpha_beta_tracker_q16 regression: pass");
    end else begin
      $display("alpha_beta_tracker_q16 regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5000000;
    $display("alpha_beta_tracker_q16 regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
design/abt_pkg.sv
design/alpha_beta_tracker_q16.sv
dv/alpha_beta_tracker_q16_test.sv
